// ----- design/pstvm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pstvm_pkg
// Types and constants shared by the per-second traffic volume meter and its
// checker: field widths, command and direction codes, register indexes and
// the layout of one bin row.
// ----------------------------------------------------------------------------
package pstvm_pkg;

    // Field widths
    localparam int TAG_W  = 8;
    localparam int MIN_W  = 6;
    localparam int SIZE_W = 16;
    localparam int DIR_W  = 2;
    localparam int SEC_W  = 32;
    localparam int BIN_W  = 40;
    localparam int SUM_W  = 48;
    localparam int AVG_W  = 51;

    // Counter lanes of one bin row
    localparam int LANES      = 3;
    localparam int LANE_TOTAL = 0;
    localparam int LANE_UP    = 1;
    localparam int LANE_DOWN  = 2;

    // Command codes
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_CLOSE  = 1'b1;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    // Configuration register indexes
    localparam logic REG_INTERFACE = 1'b0;
    localparam logic REG_ROUTER    = 1'b1;

    localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

    typedef logic [BIN_W-1:0] bin_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [AVG_W-1:0] avg_t;

    typedef struct packed {
        bin_t total;
        bin_t up;
        bin_t down;
    } bin_row_t;

    // Add a frame size to a bin counter, clamping at the counter maximum
    function automatic bin_t sat_add(bin_t bin, logic [SIZE_W-1:0] size);
        logic [BIN_W:0] s;
        s = {1'b0, bin} + (BIN_W + 1)'(size);
        return s[BIN_W] ? BIN_MAX : s[BIN_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- design/per_second_traffic_volume_meter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_second_traffic_volume_meter
// Packet commands add the frame size to a per-second bin of the bank that the
// minute parity picks; close commands walk the other bank, clear it and report
// sums, peaks and average bits per nonzero bin.
// ----------------------------------------------------------------------------
// A packet command keeps busy high until its bin is written back, so no new
// command is accepted before then: the bin index takes a fold stage and
// two multiplier stages (epoch seconds modulo BINS), then the bin memory is
// read, and written back in the cycle after. A close command keeps busy high
// while it reads every bin of the other bank in turn, drains and loads, then
// runs a bit-serial divider that forms all three averages side by side. done
// pulses for one cycle, the first cycle with busy low, with all result
// ports valid; the result must be taken in that cycle, as nothing holds it
// off. The bins are cleared at reset through per-entry valid bits, so no
// clearing pass is run. Configuration writes are always ready and take
// effect at once.
// ----------------------------------------------------------------------------
module per_second_traffic_volume_meter #(
    parameter int BINS = 100
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    output logic                          busy,
    output logic                          done,
    input  wire                           cmd,
    input  wire  [pstvm_pkg::MIN_W-1:0]   minute,
    input  wire  [pstvm_pkg::SIZE_W-1:0]  frame_size,
    input  wire  [pstvm_pkg::DIR_W-1:0]   direction,
    input  wire  [pstvm_pkg::SEC_W-1:0]   epoch_seconds,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire                           cfg_index,
    input  wire  [pstvm_pkg::TAG_W-1:0]   cfg_data,
    output logic [pstvm_pkg::TAG_W-1:0]   out_interface,
    output logic [pstvm_pkg::TAG_W-1:0]   out_router,
    output logic [pstvm_pkg::SUM_W-1:0]   total_volume,
    output logic [pstvm_pkg::SUM_W-1:0]   up_volume,
    output logic [pstvm_pkg::SUM_W-1:0]   down_volume,
    output logic [pstvm_pkg::BIN_W-1:0]   peak_total,
    output logic [pstvm_pkg::BIN_W-1:0]   peak_up,
    output logic [pstvm_pkg::BIN_W-1:0]   peak_down,
    output logic [pstvm_pkg::AVG_W-1:0]   avg_total_bits,
    output logic [pstvm_pkg::AVG_W-1:0]   avg_up_bits,
    output logic [pstvm_pkg::AVG_W-1:0]   avg_down_bits
);

    import pstvm_pkg::*;

    // Sizes derived from the bin count
    localparam int SLOTS     = 2 * BINS;
    localparam int A_W       = $clog2(SLOTS);
    localparam int BIN_IDX_W = $clog2(BINS);
    localparam int CNT_W     = $clog2(BINS + 1);
    localparam int RED_W     = SIZE_W + BIN_IDX_W + 1;
    localparam int SH        = RED_W + BIN_IDX_W;
    localparam int RCP_W     = RED_W + 2;
    localparam int Q_W       = RED_W - BIN_IDX_W + 1;
    localparam int DC_W      = $clog2(AVG_W);

    // 2^16 mod BINS folds the upper half of the seconds onto the lower half
    localparam logic [BIN_IDX_W-1:0] FOLD_C     = BIN_IDX_W'((1 << SIZE_W) % BINS);
    // Reciprocal of BINS, exact for every folded value
    localparam logic [RCP_W-1:0]     RECIP      = RCP_W'(((64'd1 << SH) / BINS) + 1);
    localparam logic [BIN_IDX_W:0]   BINS_C     = (BIN_IDX_W + 1)'(BINS);
    localparam logic [A_W-1:0]       BANK1_BASE = A_W'(BINS);
    localparam logic [BIN_IDX_W-1:0] WALK_LAST  = BIN_IDX_W'(BINS - 1);
    localparam logic [DC_W-1:0]      DIV_LAST   = DC_W'(AVG_W - 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MODQ  = 4'd1;
    localparam logic [3:0] S_MODR  = 4'd2;
    localparam logic [3:0] S_PRD   = 4'd3;
    localparam logic [3:0] S_PWR   = 4'd4;
    localparam logic [3:0] S_WALK  = 4'd5;
    localparam logic [3:0] S_WEND  = 4'd6;
    localparam logic [3:0] S_DINIT = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;

    // Control state
    logic [3:0]           state_reg, state_next;
    logic [BIN_IDX_W-1:0] walk_cnt_reg;
    logic [DC_W-1:0]      div_cnt_reg;
    logic                 walk_pend_reg;
    logic                 done_reg, done_next;
    logic [SLOTS-1:0]     valid_reg;
    logic                 rd_live_reg;
    logic [TAG_W-1:0]     iface_tag_reg;
    logic [TAG_W-1:0]     router_tag_reg;

    // Packet datapath
    logic [SIZE_W+BIN_IDX_W-1:0] fold_prod;
    logic [RED_W-1:0]            y_next, y_reg;
    logic [RED_W+RCP_W-1:0]      recip_prod;
    logic [Q_W-1:0]              q_reg;
    logic [RED_W-1:0]            r_full;
    logic [A_W-1:0]              addr_next, addr_reg;
    logic                        bank_reg;
    logic [SIZE_W-1:0]           size_reg;
    logic [DIR_W-1:0]            dir_reg;

    // Bin memory
    bin_row_t             bin_mem [SLOTS];
    bin_row_t             rd_row_reg;
    bin_row_t             cur_row;
    bin_row_t             wr_row;
    logic                 mem_re;
    logic                 mem_we;
    logic [A_W-1:0]       rd_addr;
    logic [A_W-1:0]       walk_base_reg;

    // Close lanes
    bin_t                 lane_val  [LANES];
    sum_t                 sum_reg   [LANES];
    bin_t                 peak_reg  [LANES];
    logic [CNT_W-1:0]     cnt_reg   [LANES];
    avg_t                 dvd_reg   [LANES];
    logic [CNT_W-1:0]     rem_reg   [LANES];
    logic [CNT_W:0]       trial     [LANES];
    logic [CNT_W:0]       diff      [LANES];
    logic                 q_bit     [LANES];
    logic [CNT_W-1:0]     rem_next  [LANES];

    logic                 accept;
    logic                 cfg_write;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign done      = done_reg;

    // Sequence packet and close commands
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (cmd == CMD_CLOSE) ? S_WALK : S_MODQ;
                end
            end
            S_MODQ:  state_next = S_MODR;
            S_MODR:  state_next = S_PRD;
            S_PRD:   state_next = S_PWR;
            S_PWR:   state_next = S_IDLE;
            S_WALK:
            begin
                if (walk_cnt_reg == WALK_LAST)
                begin
                    state_next = S_WEND;
                end
            end
            S_WEND:  state_next = S_DINIT;
            S_DINIT: state_next = S_DIV;
            S_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign done_next = (state_reg == S_DIV) && (div_cnt_reg == DIV_LAST);

    // Fold the seconds to a narrow value with the same residue
    assign fold_prod = epoch_seconds[SEC_W-1:SIZE_W] * FOLD_C;
    assign y_next    = RED_W'(fold_prod) + RED_W'(epoch_seconds[SIZE_W-1:0]);

    // Quotient by reciprocal, remainder by back-multiplication
    assign recip_prod = y_reg * RECIP;
    assign r_full     = y_reg - (RED_W'(q_reg) * RED_W'(BINS_C));
    assign addr_next  = (bank_reg ? BANK1_BASE : {A_W{1'b0}})
                      + A_W'(r_full[BIN_IDX_W-1:0]);

    // Memory access selection
    assign mem_re  = (state_reg == S_PRD) || (state_reg == S_WALK);
    assign mem_we  = (state_reg == S_PWR);
    assign rd_addr = (state_reg == S_WALK) ? walk_base_reg + A_W'(walk_cnt_reg) : addr_reg;

    // A bin never written since reset or since its last walk reads as zero
    assign cur_row = rd_live_reg ? rd_row_reg : '0;

    // Update the bin row of a packet
    always_comb
    begin
        wr_row.total = sat_add(cur_row.total, size_reg);
        wr_row.up    = (dir_reg == DIR_UP)   ? sat_add(cur_row.up, size_reg)   : cur_row.up;
        wr_row.down  = (dir_reg == DIR_DOWN) ? sat_add(cur_row.down, size_reg) : cur_row.down;
    end

    // Split the row into lanes and form one divider step per lane
    always_comb
    begin
        lane_val[LANE_TOTAL] = cur_row.total;
        lane_val[LANE_UP]    = cur_row.up;
        lane_val[LANE_DOWN]  = cur_row.down;
        for (int l = 0; l < LANES; l++)
        begin
            trial[l]    = {rem_reg[l], dvd_reg[l][AVG_W-1]};
            diff[l]     = trial[l] - {1'b0, cnt_reg[l]};
            q_bit[l]    = (trial[l] >= {1'b0, cnt_reg[l]});
            rem_next[l] = q_bit[l] ? diff[l][CNT_W-1:0] : trial[l][CNT_W-1:0];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            walk_cnt_reg   <= '0;
            div_cnt_reg    <= '0;
            walk_pend_reg  <= 1'b0;
            done_reg       <= 1'b0;
            valid_reg      <= '0;
            rd_live_reg    <= 1'b0;
            iface_tag_reg  <= '0;
            router_tag_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            walk_pend_reg <= (state_reg == S_WALK);

            // Advance the walk and divider counters
            if (accept)
            begin
                walk_cnt_reg <= '0;
            end
            else if (state_reg == S_WALK)
            begin
                walk_cnt_reg <= walk_cnt_reg + 1'b1;
            end
            if (state_reg == S_DINIT)
            begin
                div_cnt_reg <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end

            // Track written bins; drop each bin as the walk reads it
            if (mem_re)
            begin
                rd_live_reg <= valid_reg[rd_addr];
            end
            if (mem_we)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (state_reg == S_WALK)
            begin
                valid_reg[rd_addr] <= 1'b0;
            end

            // Take configuration transfers
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_INTERFACE: iface_tag_reg  <= cfg_data;
                    REG_ROUTER:    router_tag_reg <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    // Bin memory: one read and one write port, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem[addr_reg] <= wr_row;
        end
        if (mem_re)
        begin
            rd_row_reg <= bin_mem[rd_addr];
        end
    end

    // Packet pipeline registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            y_reg         <= y_next;
            bank_reg      <= minute[0];
            size_reg      <= frame_size;
            dir_reg       <= direction;
            walk_base_reg <= minute[0] ? {A_W{1'b0}} : BANK1_BASE;
        end
        if (state_reg == S_MODQ)
        begin
            q_reg <= recip_prod[SH +: Q_W];
        end
        if (state_reg == S_MODR)
        begin
            addr_reg <= addr_next;
        end
    end

    // Accumulate the walk and run the dividers
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (accept && (cmd == CMD_CLOSE))
            begin
                sum_reg[l]  <= '0;
                peak_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
            else if (walk_pend_reg)
            begin
                sum_reg[l] <= sum_reg[l] + SUM_W'(lane_val[l]);
                if (lane_val[l] > peak_reg[l])
                begin
                    peak_reg[l] <= lane_val[l];
                end
                if (lane_val[l] != '0)
                begin
                    cnt_reg[l] <= cnt_reg[l] + 1'b1;
                end
            end
            if (state_reg == S_DINIT)
            begin
                dvd_reg[l] <= {sum_reg[l], 3'b000};
                rem_reg[l] <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                dvd_reg[l] <= {dvd_reg[l][AVG_W-2:0], q_bit[l]};
                rem_reg[l] <= rem_next[l];
            end
        end
    end

    // Result ports
    assign out_interface  = iface_tag_reg;
    assign out_router     = router_tag_reg;
    assign total_volume   = sum_reg[LANE_TOTAL];
    assign up_volume      = sum_reg[LANE_UP];
    assign down_volume    = sum_reg[LANE_DOWN];
    assign peak_total     = peak_reg[LANE_TOTAL];
    assign peak_up        = peak_reg[LANE_UP];
    assign peak_down      = peak_reg[LANE_DOWN];
    assign avg_total_bits = (cnt_reg[LANE_TOTAL] == '0) ? '0 : dvd_reg[LANE_TOTAL];
    assign avg_up_bits    = (cnt_reg[LANE_UP] == '0)    ? '0 : dvd_reg[LANE_UP];
    assign avg_down_bits  = (cnt_reg[LANE_DOWN] == '0)  ? '0 : dvd_reg[LANE_DOWN];

endmodule
`default_nettype wire

// ----- design/pstvm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pstvm_checker
// Port-level checks of the traffic volume meter, bound to the top level.
// ----------------------------------------------------------------------------
module pstvm_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          start,
    input wire                          busy,
    input wire                          done,
    input wire [pstvm_pkg::SUM_W-1:0]   total_volume,
    input wire [pstvm_pkg::SUM_W-1:0]   up_volume,
    input wire [pstvm_pkg::SUM_W-1:0]   down_volume,
    input wire [pstvm_pkg::BIN_W-1:0]   peak_total,
    input wire [pstvm_pkg::AVG_W-1:0]   avg_total_bits
);

    import pstvm_pkg::*;

    // An accepted command always occupies the block for at least one cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted command");

    // A close yields a single result transfer
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // No single bin can exceed the sum over the bank
    a_peak_le_sum: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({{(SUM_W - BIN_W){1'b0}}, peak_total} <= total_volume))
        else $error("peak total exceeds total volume");

    // Directional volumes are part of the total
    a_dir_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((up_volume <= total_volume) && (down_volume <= total_volume)))
        else $error("directional volume exceeds total volume");

    // An empty bank reports a zero average
    a_zero_avg: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (total_volume == '0)) |-> (avg_total_bits == '0))
        else $error("nonzero average for an empty bank");

endmodule

bind per_second_traffic_volume_meter pstvm_checker u_pstvm_checker (.*);
`default_nettype wire
